// ===== sv/bba_pkg.sv =====
`timescale 1ns / 1ps
package bba_pkg;

  localparam int unsigned HeapBytesDefault = 1048576;
  localparam int unsigned MinBlockBytesDefault = 4096;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_USED  = 2'd1;
  localparam logic [1:0] ST_SPLIT = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ROUND,
    S_RD,
    S_WAIT,
    S_EVAL,
    S_UP,
    S_CHK_RD,
    S_CHK_WAIT,
    S_CHK_EVAL,
    S_DONE
  } state_t;

endpackage

// ===== sv/bba_if.sv =====
`timescale 1ns / 1ps
interface bba_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] request_size;
  logic [31:0] free_address;
  modport source (output valid, command, request_size, free_address, input ready);
  modport sink   (input valid, command, request_size, free_address, output ready);
endinterface

interface bba_rsp_if;
  logic        valid;
  logic        ready;
  logic        success;
  logic [31:0] block_address;
  logic [31:0] granted_size;
  modport source (output valid, success, block_address, granted_size, input ready);
  modport sink   (input valid, success, block_address, granted_size, output ready);
endinterface

// ===== sv/bba_ram.sv =====
`timescale 1ns / 1ps
module bba_ram #(
  parameter int Width = 2,
  parameter int Depth = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/buddy_block_allocator.sv =====
`timescale 1ns / 1ps
// Binary buddy allocator over a tree of block states kept in one RAM.
// Input channel (in): command 0 allocates request_size bytes, 1 releases
// the block at free_address. One result beat per request on out: success,
// block_address (heap_base + offset) and granted_size for an allocate.
// cfg_we/cfg_wdata write heap_base; write it only while the block is idle.
// A request is walked depth-first through the node RAM by one sequencer.
// Each visited node takes a RAM read, a read wait and an evaluate and
// write-back state, and each step back up one more; once a free finds
// its block, it reads both children at each level on the way back up
// and merges the parent when both are free.
// in_ready is high only in the idle state with no result pending: one
// request at a time.
// After reset the sequencer clears every node to free, one node a cycle,
// before accepting a request.
// The result register holds its beat while out_ready is low; the next
// request is taken only after the result is taken.
module buddy_block_allocator #(
  parameter int unsigned HEAP_BYTES      = bba_pkg::HeapBytesDefault,
  parameter int unsigned MIN_BLOCK_BYTES = bba_pkg::MinBlockBytesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  bba_req_if.sink     in_req,
  bba_rsp_if.source   out_rsp
);
  import bba_pkg::*;

  localparam int unsigned Leaves = HEAP_BYTES / MIN_BLOCK_BYTES;
  localparam int unsigned Slots  = 4 * Leaves;
  localparam int unsigned AW     = $clog2(Slots);
  localparam int unsigned DW     = $clog2(AW);   // depth counter
  localparam logic [33:0] Heap34 = 34'(HEAP_BYTES);
  localparam logic [33:0] Min34  = 34'(MIN_BLOCK_BYTES);

  state_t state_r, state_nxt;

  logic [31:0] heap_base_r;
  logic        cmd_r;
  logic [33:0] req_r, want_r;
  logic [31:0] addr_r;
  logic [33:0] idx_r, size_r, off_r;
  logic [DW-1:0] dep_r;
  logic [2**DW-1:0] path_r;       // per depth: 1 = currently in right child
  logic        done_r;            // result of last child return
  logic        left_free_r;
  logic        succ_r;
  logic [31:0] baddr_r, gsize_r;
  logic        ovalid_r;
  logic [AW-1:0] clr_r;

  // RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [1:0]    wdata, rdata;

  bba_ram #(.Width(2), .Depth(Slots)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  wire idx_ok = (idx_r < 34'(Slots));
  wire [1:0] st = idx_ok ? rdata : ST_USED;
  wire [33:0] half = size_r >> 1;
  wire has_kids = size_r > Min34;
  wire addr_hit = (heap_base_r + off_r[31:0]) == addr_r;
  wire alloc_hit = (st == ST_FREE) && (size_r == want_r);
  wire free_hit = (st == ST_USED) && addr_hit;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:    if (clr_r == AW'(Slots - 1)) state_nxt = S_IDLE;
      S_IDLE:     if (in_req.valid && !ovalid_r) state_nxt = S_ROUND;
      S_ROUND: begin
        if (cmd_r == CMD_ALLOC && req_r > Heap34) state_nxt = S_DONE;
        else if (cmd_r == CMD_FREE || want_r >= req_r) state_nxt = S_RD;
      end
      S_RD:       state_nxt = S_WAIT;
      S_WAIT:     state_nxt = S_EVAL;
      S_EVAL: begin
        if (cmd_r == CMD_ALLOC) begin
          if ((st == ST_FREE || st == ST_SPLIT) && want_r <= size_r &&
              !(st == ST_FREE && size_r == want_r) && has_kids) state_nxt = S_RD;
          else state_nxt = S_UP;
        end else begin
          if (st == ST_SPLIT && has_kids) state_nxt = S_RD;
          else state_nxt = S_UP;
        end
      end
      S_UP: begin
        if (dep_r == '0) state_nxt = S_DONE;
        else if (done_r) begin
          state_nxt = (cmd_r == CMD_FREE) ? S_CHK_RD : S_UP;
        end else if (!path_r[dep_r - DW'(1)]) state_nxt = S_RD;
        else state_nxt = S_UP;
      end
      S_CHK_RD:   state_nxt = S_CHK_WAIT;
      S_CHK_WAIT: state_nxt = S_CHK_EVAL;
      S_CHK_EVAL: state_nxt = (idx_r[0]) ? S_UP : S_CHK_RD;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs and RAM control
  always_comb begin
    we = 1'b0; waddr = idx_r[AW-1:0]; wdata = ST_FREE; raddr = idx_r[AW-1:0];
    case (state_r)
      S_CLEAR: begin
        we = 1'b1; waddr = clr_r;
      end
      S_EVAL: begin
        if (idx_ok) begin
          if (cmd_r == CMD_ALLOC) begin
            if (st == ST_FREE && want_r <= size_r) begin
              we = 1'b1; wdata = (size_r == want_r) ? ST_USED : ST_SPLIT;
            end
          end else if (st == ST_USED && addr_hit) begin
            we = 1'b1; wdata = ST_FREE;
          end
        end
      end
      S_CHK_EVAL: begin
        // at right child: merge parent if both children free
        if (idx_r[0] && left_free_r && st == ST_FREE) begin
          we = 1'b1; waddr = AW'(idx_r >> 1); wdata = ST_FREE;
        end
      end
      default: ;
    endcase
  end

  assign in_req.ready      = (state_r == S_IDLE) && !ovalid_r;
  assign out_rsp.valid         = ovalid_r;
  assign out_rsp.success       = succ_r;
  assign out_rsp.block_address = baddr_r;
  assign out_rsp.granted_size  = gsize_r;

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; ovalid_r <= 1'b0; heap_base_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) heap_base_r <= cfg_wdata;
      // raise the result beat when done, drop it once taken
      if (state_r == S_DONE) ovalid_r <= 1'b1;
      else if (out_rsp.ready) ovalid_r <= 1'b0;
      case (state_r)
        S_CLEAR: clr_r <= clr_r + AW'(1);
        S_IDLE: if (in_req.valid && !ovalid_r) begin
          cmd_r <= in_req.command; req_r <= 34'(in_req.request_size);
          addr_r <= in_req.free_address; want_r <= Min34;
          idx_r <= 34'd1; size_r <= Heap34; off_r <= '0; dep_r <= '0;
          done_r <= 1'b0; succ_r <= 1'b0; baddr_r <= '0; gsize_r <= '0;
        end
        S_ROUND: if (cmd_r == CMD_ALLOC && want_r < req_r) want_r <= want_r << 1;
        S_EVAL: begin
          if (state_nxt == S_RD) begin
            // descend into left child
            path_r[dep_r] <= 1'b0; dep_r <= dep_r + DW'(1);
            idx_r <= idx_r << 1; size_r <= half;
          end else if (cmd_r == CMD_ALLOC) begin
            done_r <= alloc_hit;
            if (alloc_hit) begin
              succ_r <= 1'b1;
              baddr_r <= heap_base_r + off_r[31:0]; gsize_r <= want_r[31:0];
            end
          end else begin
            done_r <= free_hit;
            if (free_hit) succ_r <= 1'b1;
          end
        end
        S_UP: if (dep_r != '0) begin
          if (done_r) begin
            // free: go check siblings starting with left child of parent
            if (cmd_r == CMD_FREE) idx_r <= {idx_r[33:1], 1'b0};
            else begin
              idx_r <= idx_r >> 1; size_r <= size_r << 1;
              if (path_r[dep_r - DW'(1)]) off_r <= off_r - size_r;
              dep_r <= dep_r - DW'(1);
            end
          end else if (!path_r[dep_r - DW'(1)]) begin
            // try right sibling
            path_r[dep_r - DW'(1)] <= 1'b1;
            idx_r <= idx_r | 34'd1; off_r <= off_r + size_r;
          end else begin
            idx_r <= idx_r >> 1; size_r <= size_r << 1;
            off_r <= off_r - size_r; dep_r <= dep_r - DW'(1);
          end
        end
        S_CHK_EVAL: begin
          if (!idx_r[0]) begin
            left_free_r <= (st == ST_FREE); idx_r <= idx_r | 34'd1;
          end else begin
            // pop one level
            if (path_r[dep_r - DW'(1)]) off_r <= off_r - size_r;
            idx_r <= idx_r >> 1; size_r <= size_r << 1; dep_r <= dep_r - DW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule
